// ===== design/rv32im_execute_unit_core_assert.svh =====
// Assertion macros shared by the execute unit.
// No dependencies; included inside the module body of the top level.
`ifndef RV32IM_EXECUTE_UNIT_CORE_ASSERT_SVH
`define RV32IM_EXECUTE_UNIT_CORE_ASSERT_SVH

// When the antecedent holds, the consequent must hold in the same cycle.
`define RV_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define RV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/rv32_pkg.sv =====
// Shared types and constants of the RV32IM execute unit.
// No dependencies; used by the controller, the datapath and the top level.
package rv32_pkg;

  localparam int REG_COUNT_DEF = 32;

  // Major opcodes.
  localparam logic [6:0] OP_LUI    = 7'b0110111;
  localparam logic [6:0] OP_AUIPC  = 7'b0010111;
  localparam logic [6:0] OP_JAL    = 7'b1101111;
  localparam logic [6:0] OP_JALR   = 7'b1100111;
  localparam logic [6:0] OP_BRANCH = 7'b1100011;
  localparam logic [6:0] OP_LOAD   = 7'b0000011;
  localparam logic [6:0] OP_STORE  = 7'b0100011;
  localparam logic [6:0] OP_IMM    = 7'b0010011;
  localparam logic [6:0] OP_REG    = 7'b0110011;
  localparam logic [6:0] OP_FENCE  = 7'b0001111;
  localparam logic [6:0] OP_SYSTEM = 7'b1110011;

  localparam logic [6:0] F7_ALT    = 7'b0100000;
  localparam logic [6:0] F7_MULDIV = 7'b0000001;

  // Trap codes.
  localparam logic [2:0] TRAP_NONE    = 3'd0;
  localparam logic [2:0] TRAP_ILLEGAL = 3'd1;
  localparam logic [2:0] TRAP_ECALL   = 3'd2;
  localparam logic [2:0] TRAP_EBREAK  = 3'd3;
  localparam logic [2:0] TRAP_LFAULT  = 3'd4;

  // Memory request codes.
  localparam logic [1:0] MEM_NONE  = 2'd0;
  localparam logic [1:0] MEM_LOAD  = 2'd1;
  localparam logic [1:0] MEM_STORE = 2'd2;

  typedef struct packed {
    logic               mode;
    logic [6:0]         opcode;
    logic [2:0]         funct3;
    logic [6:0]         funct7;
    logic [4:0]         dest_index;
    logic [4:0]         src1_index;
    logic [4:0]         src2_index;
    logic signed [31:0] immediate;
    logic [31:0]        program_counter;
    logic [31:0]        load_data;
    logic               load_fault;
  } req_t;

  typedef struct packed {
    logic [31:0] dest_value;
    logic        dest_written;
    logic [31:0] next_pc;
    logic [1:0]  mem_access;
    logic [1:0]  mem_size;
    logic [31:0] mem_address;
    logic [31:0] store_data;
    logic [2:0]  trap;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_MUL, ST_MULFIX, ST_DIVINIT, ST_DIV, ST_DIVFIX, ST_FIN
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic rd;
    logic mul;
    logic mulfix;
    logic divinit;
    logic divstep;
    logic divfix;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_mul;
    logic is_div;
    logic div_last;
  } sts_t;

endpackage

// ===== design/rv32_ctrl.sv =====
// Controller state machine of the RV32IM execute unit.
// Depends on rv32_pkg; drives the datapath through cmd_t and reads sts_t.
module rv32_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output rv32_pkg::cmd_t cmd,
  input  rv32_pkg::sts_t sts
);
  import rv32_pkg::*;

  state_t state, state_next;

  // State register and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign req_stall = (state != ST_IDLE);

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd = 1'b1;
        if (sts.is_mul) begin
          state_next = ST_MUL;
        end else if (sts.is_div) begin
          state_next = ST_DIVINIT;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_MULFIX;
      end
      ST_MULFIX: begin
        cmd.mulfix = 1'b1;
        state_next = ST_FIN;
      end
      ST_DIVINIT: begin
        cmd.divinit = 1'b1;
        state_next  = ST_DIV;
      end
      ST_DIV: begin
        cmd.divstep = 1'b1;
        if (sts.div_last) begin
          state_next = ST_DIVFIX;
        end
      end
      ST_DIVFIX: begin
        cmd.divfix = 1'b1;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (!rsp_valid || !rsp_stall) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/rv32_dp.sv =====
// Datapath of the RV32IM execute unit: register file, ALU, multiplier,
// iterative divider and output register. Depends on rv32_pkg.
module rv32_dp #(
  parameter int REG_COUNT = rv32_pkg::REG_COUNT_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  rv32_pkg::req_t req,
  output rv32_pkg::rsp_t rsp,
  input  rv32_pkg::cmd_t cmd,
  output rv32_pkg::sts_t sts
);
  import rv32_pkg::*;

  localparam int IW = $clog2(REG_COUNT);

  req_t              item;
  logic [31:0]       regs [REG_COUNT];
  logic [REG_COUNT-1:0] valid;
  logic [31:0]       a_raw, b_raw, a, b;
  logic              a_ok, b_ok;
  logic [4:0]        pend_dest;
  logic [2:0]        pend_kind;
  logic [63:0]       prod;
  logic [31:0]       md_res;
  logic [31:0]       dq, dr, dd;
  logic [4:0]        cnt;
  logic              a_neg, b_neg, sgn, b_zero;
  logic [32:0]       div_sh, div_diff;
  rsp_t              res;
  logic              do_write, wr_en, alt, taken, illegal_ld;
  logic [4:0]        wr_idx;
  logic [31:0]       op2, alu, pc4, sum_a;
  logic [4:0]        sh;

  // Input item register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= req;
    end
  end

  // Register file read, registered, with an in-range and written check.
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      a_raw <= regs[item.src1_index[IW-1:0]];
      b_raw <= regs[item.src2_index[IW-1:0]];
      a_ok  <= (item.src1_index != 5'd0) && ({1'b0, item.src1_index} < 6'(REG_COUNT))
               && valid[item.src1_index[IW-1:0]];
      b_ok  <= (item.src2_index != 5'd0) && ({1'b0, item.src2_index} < 6'(REG_COUNT))
               && valid[item.src2_index[IW-1:0]];
    end
  end
  assign a = a_ok ? a_raw : 32'd0;
  assign b = b_ok ? b_raw : 32'd0;

  // Register file write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      regs[wr_idx[IW-1:0]] <= res.dest_value;
    end
  end

  // Written flags and pending load state.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      pend_dest <= 5'd0;
      pend_kind <= 3'd0;
    end else if (cmd.finish) begin
      if (wr_en) begin
        valid[wr_idx[IW-1:0]] <= 1'b1;
      end
      if (item.mode) begin
        pend_dest <= 5'd0;
      end else if (item.opcode == OP_LOAD && !illegal_ld) begin
        pend_dest <= item.dest_index;
        pend_kind <= item.funct3;
      end
    end
  end

  // Decode status for the controller.
  always_comb begin
    sts.is_mul   = !item.mode && item.opcode == OP_REG && item.funct7 == F7_MULDIV
                   && !item.funct3[2];
    sts.is_div   = !item.mode && item.opcode == OP_REG && item.funct7 == F7_MULDIV
                   && item.funct3[2];
    sts.div_last = (cnt == 5'd31);
  end

  assign a_neg  = a[31];
  assign b_neg  = b[31];
  assign sgn    = !item.funct3[0];
  assign b_zero = (b == 32'd0);

  // Multiplier: unsigned product, then sign correction of the high word.
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= a * b;
    end
  end

  // Restoring divider on magnitudes, one quotient bit per cycle.
  assign div_sh   = {dr, dq[31]};
  assign div_diff = div_sh - {1'b0, dd};

  always_ff @(posedge clk) begin
    if (cmd.divinit) begin
      dq  <= (sgn && a_neg) ? (32'd0 - a) : a;
      dd  <= (sgn && b_neg) ? (32'd0 - b) : b;
      dr  <= 32'd0;
      cnt <= 5'd0;
    end else if (cmd.divstep) begin
      dr  <= div_diff[32] ? div_sh[31:0] : div_diff[31:0];
      dq  <= {dq[30:0], !div_diff[32]};
      cnt <= cnt + 5'd1;
    end
  end

  // Final M-extension result.
  always_ff @(posedge clk) begin
    if (cmd.mulfix) begin
      case (item.funct3[1:0])
        2'd0: md_res <= prod[31:0];
        2'd1: md_res <= prod[63:32] - (a_neg ? b : 32'd0) - (b_neg ? a : 32'd0);
        2'd2: md_res <= prod[63:32] - (a_neg ? b : 32'd0);
        default: md_res <= prod[63:32];
      endcase
    end else if (cmd.divfix) begin
      if (!item.funct3[1]) begin
        if (b_zero) begin
          md_res <= 32'hFFFF_FFFF;
        end else begin
          md_res <= (sgn && (a_neg ^ b_neg)) ? (32'd0 - dq) : dq;
        end
      end else begin
        if (b_zero) begin
          md_res <= a;
        end else begin
          md_res <= (sgn && a_neg) ? (32'd0 - dr) : dr;
        end
      end
    end
  end

  // Base ALU.
  assign op2   = (item.opcode == OP_IMM) ? item.immediate : b;
  assign sh    = op2[4:0];
  assign alt   = (item.opcode == OP_IMM)
                 ? (item.funct3 == 3'd5 && item.funct7 == F7_ALT)
                 : (item.funct7 == F7_ALT && (item.funct3 == 3'd0 || item.funct3 == 3'd5));
  assign pc4   = item.program_counter + 32'd4;
  assign sum_a = a + item.immediate;
  assign illegal_ld = (item.funct3 == 3'd3) || (item.funct3 > 3'd5);

  always_comb begin
    case (item.funct3)
      3'd0: alu = alt ? (a - op2) : (a + op2);
      3'd1: alu = a << sh;
      3'd2: alu = {31'd0, $signed(a) < $signed(op2)};
      3'd3: alu = {31'd0, a < op2};
      3'd4: alu = a ^ op2;
      3'd5: alu = alt ? 32'($signed(a) >>> sh) : (a >> sh);
      3'd6: alu = a | op2;
      default: alu = a & op2;
    endcase
  end

  // Branch condition.
  always_comb begin
    case (item.funct3)
      3'd0: taken = (a == b);
      3'd1: taken = (a != b);
      3'd4: taken = $signed(a) < $signed(b);
      3'd5: taken = !($signed(a) < $signed(b));
      3'd6: taken = a < b;
      3'd7: taken = a >= b;
      default: taken = 1'b0;
    endcase
  end

  // Result of the item.
  always_comb begin
    res      = '0;
    res.next_pc = pc4;
    do_write = 1'b0;
    wr_idx   = item.dest_index;
    if (item.mode) begin
      res.next_pc = 32'd0;
      if (item.load_fault) begin
        res.trap = TRAP_LFAULT;
      end else begin
        case (pend_kind)
          3'd0: res.dest_value = {{24{item.load_data[7]}}, item.load_data[7:0]};
          3'd1: res.dest_value = {{16{item.load_data[15]}}, item.load_data[15:0]};
          3'd4: res.dest_value = {24'd0, item.load_data[7:0]};
          3'd5: res.dest_value = {16'd0, item.load_data[15:0]};
          default: res.dest_value = item.load_data;
        endcase
        wr_idx   = pend_dest;
        do_write = 1'b1;
      end
    end else begin
      case (item.opcode)
        OP_LUI: begin
          res.dest_value = item.immediate;
          do_write = 1'b1;
        end
        OP_AUIPC: begin
          res.dest_value = item.program_counter + item.immediate;
          do_write = 1'b1;
        end
        OP_JAL: begin
          res.dest_value = pc4;
          res.next_pc = item.program_counter + item.immediate;
          do_write = 1'b1;
        end
        OP_JALR: begin
          res.dest_value = pc4;
          res.next_pc = {sum_a[31:1], 1'b0};
          do_write = 1'b1;
        end
        OP_BRANCH: begin
          if (item.funct3 == 3'd2 || item.funct3 == 3'd3) begin
            res.trap = TRAP_ILLEGAL;
          end else if (taken) begin
            res.next_pc = item.program_counter + item.immediate;
          end
        end
        OP_LOAD: begin
          if (illegal_ld) begin
            res.trap = TRAP_ILLEGAL;
          end else begin
            res.mem_access  = MEM_LOAD;
            res.mem_size    = {1'b0, item.funct3[1:0]} == 3'd3 ? 2'd0 : item.funct3[1:0];
            res.mem_address = sum_a;
          end
        end
        OP_STORE: begin
          if (item.funct3 > 3'd2) begin
            res.trap = TRAP_ILLEGAL;
          end else begin
            res.mem_access  = MEM_STORE;
            res.mem_size    = item.funct3[1:0];
            res.mem_address = sum_a;
            case (item.funct3[1:0])
              2'd0: res.store_data = {24'd0, b[7:0]};
              2'd1: res.store_data = {16'd0, b[15:0]};
              default: res.store_data = b;
            endcase
          end
        end
        OP_IMM: begin
          res.dest_value = alu;
          do_write = 1'b1;
        end
        OP_REG: begin
          if (item.funct7 == F7_MULDIV) begin
            res.dest_value = md_res;
            do_write = 1'b1;
          end else if (item.funct7 == 7'd0 || item.funct7 == F7_ALT) begin
            res.dest_value = alu;
            do_write = 1'b1;
          end
        end
        OP_FENCE: begin
        end
        OP_SYSTEM: begin
          if (item.funct3 == 3'd0 && item.immediate == 32'sd0) begin
            res.trap = TRAP_ECALL;
          end else if (item.funct3 == 3'd0 && item.immediate == 32'sd1) begin
            res.trap = TRAP_EBREAK;
          end else begin
            res.trap = TRAP_ILLEGAL;
          end
        end
        default: begin
          res.trap = TRAP_ILLEGAL;
        end
      endcase
    end
    res.dest_written = do_write && (wr_idx != 5'd0) && ({1'b0, wr_idx} < 6'(REG_COUNT));
    if (!res.dest_written) begin
      res.dest_value = 32'd0;
    end
  end

  assign wr_en = cmd.finish && res.dest_written;

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rsp <= res;
    end
  end

endmodule

// ===== design/rv32im_execute_unit_core.sv =====
// Top level of the RV32IM execute unit: controller plus datapath.
// Depends on rv32_pkg, rv32_ctrl, rv32_dp and the assertion macro header.
//
//   Channel   Signals                      Direction
//   request   req_valid, req_stall, req    in  (req_stall driven here)
//   response  rsp_valid, rsp_stall, rsp    out (rsp_stall driven by sink)
//
// ALU, branch, jump, load, store and return items pass the read and finish
// states to the result register; MUL/MULH* add the multiply and fix states,
// DIV/REM the divider init, step and fix. One item is in flight at a time.
// Reset clears the controller, pending load state and register written flags.
// A stalled result holds the finish state until the output register frees.
module rv32im_execute_unit_core #(
  parameter int REG_COUNT = rv32_pkg::REG_COUNT_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  rv32_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output rv32_pkg::rsp_t rsp
);
  import rv32_pkg::*;
  `include "rv32im_execute_unit_core_assert.svh"

  cmd_t cmd;
  sts_t sts;

  rv32_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  rv32_dp #(
    .REG_COUNT (REG_COUNT)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cmd (cmd),
    .sts (sts)
  );

  // An accepted item keeps the block busy in the following cycle.
  `RV_ASSERT_NEXT(a_busy_after_accept, clk, rst, req_valid && !req_stall, req_stall, "not busy")
  // A trapping result never writes a register.
  `RV_ASSERT_SAME(a_trap_no_write, clk, rst, rsp_valid && rsp.trap != TRAP_NONE,
    !rsp.dest_written, "trap wrote a register")
  // A memory request never writes a register.
  `RV_ASSERT_SAME(a_mem_no_write, clk, rst, rsp_valid && rsp.mem_access != MEM_NONE,
    !rsp.dest_written, "memory request wrote a register")
  // The result register is loaded only while the block is busy with an item.
  `RV_ASSERT_SAME(a_finish_busy, clk, rst, cmd.finish, req_stall, "finish while idle")

endmodule
